/* hw/rtl/dscq_pkg.sv */
// ----------------------------------------------------------------------------
// dscq_pkg
// Shared types and constants of the deadline sorted callout queue.
// ----------------------------------------------------------------------------
package dscq_pkg;

   localparam logic [2:0] CMD_ARM_AT    = 3'd0;
   localparam logic [2:0] CMD_ARM_AFTER = 3'd1;
   localparam logic [2:0] CMD_CANCEL    = 3'd2;
   localparam logic [2:0] CMD_SERVICE   = 3'd3;
   localparam logic [2:0] CMD_QUERY     = 3'd4;

   localparam logic [15:0] INTERVAL_MIN_RESET = 16'd50;
   localparam logic [15:0] INTERVAL_MAX_RESET = 16'd50000;

   localparam logic CSR_INTERVAL_MIN = 1'b0;
   localparam logic CSR_INTERVAL_MAX = 1'b1;

   // Datapath operations requested by the controller
   localparam logic [3:0] OP_NONE      = 4'd0;
   localparam logic [3:0] OP_LOAD      = 4'd1;  // latch request, point at slot
   localparam logic [3:0] OP_RM_START  = 4'd2;  // start unlink of target
   localparam logic [3:0] OP_RM_STEP   = 4'd3;  // advance unlink walk
   localparam logic [3:0] OP_WRITE     = 4'd4;  // write slot fields
   localparam logic [3:0] OP_INS_START = 4'd5;
   localparam logic [3:0] OP_INS_STEP  = 4'd6;
   localparam logic [3:0] OP_FIRE      = 4'd7;  // pick head as target
   localparam logic [3:0] OP_REARM     = 4'd8;  // deadline += period
   localparam logic [3:0] OP_CLEAR     = 4'd9;  // cancel clears fields
   localparam logic [3:0] OP_DELAY     = 4'd10; // compute next delay
   localparam logic [3:0] OP_DELAY2    = 4'd11; // clamp next delay

   typedef struct packed {
      logic [3:0] op;
   } ctrl_type;

   typedef struct packed {
      logic target_queued;
      logic target_ok;
      logic rm_done;
      logic ins_done;
      logic head_due;
      logic has_period;
   } stat_type;

endpackage

/* hw/rtl/deadline_sorted_callout_queue_core.sv */
// ----------------------------------------------------------------------------
// deadline_sorted_callout_queue_core
// A request is accepted only while the core is idle, and the next one waits
// until the last response of the current one is taken. A query or an unused
// command passes the load state and the two delay states to the output; a
// cancel of an idle slot also clears it, a service that fires nothing also
// checks the head first, and an arm of an idle slot also writes and inserts it.
// Unlinking a queued slot walks the list entries before it, and a sorted
// insert walks the entries that it passes. A service unlinks and records each
// fired slot, and rearms and reinserts a periodic one. Responses leave one per
// cycle while rsp_tready is high, and req_tready returns the cycle after the
// last one is taken. The linked-list walks set the rate.
// ----------------------------------------------------------------------------
module deadline_sorted_callout_queue_core #(
   parameter int SLOTS     = 16,
   parameter int MAX_FIRES = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // cmd[2:0] slot[6:3] now[70:7] when[134:71] period[198:135] has_action[199]
   input  logic [199:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // fired_valid[0] fired_slot[4:1] fired_action[5] slot_done[6]
   // next_delay[22:7] more_pending[23]
   output logic [23:0]  rsp_tdata,
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic         csr_idx,
   input  logic [15:0]  csr_data
);

   dscq_pkg::ctrl_type ctrl;
   dscq_pkg::stat_type stat;
   logic [3:0]  fire_slot;
   logic        fire_action;
   logic [15:0] delay;
   logic        target_queued;

   dscq_datapath #(.SLOTS(SLOTS)) u_dp (
      .clock, .reset, .ctrl, .stat,
      .req_cmd(req_tdata[2:0]), .req_slot(req_tdata[6:3]),
      .req_now(req_tdata[70:7]), .req_when(req_tdata[134:71]),
      .req_period(req_tdata[198:135]), .req_action(req_tdata[199]),
      .csr_we, .csr_idx, .csr_data,
      .fire_slot, .fire_action, .delay, .target_queued
   );

   dscq_controller #(.MAX_FIRES(MAX_FIRES)) u_ctl (
      .clock, .reset, .req_tvalid, .req_tready, .req_cmd(req_tdata[2:0]),
      .ctrl, .stat, .fire_slot, .fire_action, .delay, .target_queued,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
   );

endmodule

/* hw/rtl/dscq_datapath.sv */
// ----------------------------------------------------------------------------
// dscq_datapath
// Slot storage, linked list and delay arithmetic of the callout queue.
// ----------------------------------------------------------------------------
module dscq_datapath #(
   parameter int SLOTS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  dscq_pkg::ctrl_type  ctrl,
   output dscq_pkg::stat_type  stat,
   input  logic [2:0]          req_cmd,
   input  logic [3:0]          req_slot,
   input  logic [63:0]         req_now,
   input  logic [63:0]         req_when,
   input  logic [63:0]         req_period,
   input  logic                req_action,
   input  logic                csr_we,
   input  logic                csr_idx,
   input  logic [15:0]         csr_data,
   output logic [3:0]          fire_slot,
   output logic                fire_action,
   output logic [15:0]         delay,
   output logic                target_queued
);

   localparam int LW = $clog2(SLOTS + 1);
   localparam int SW = $clog2(SLOTS);
   localparam logic [LW-1:0] NO_LINK = LW'(SLOTS);

   logic [63:0]   dl_ff [SLOTS];
   logic [63:0]   dl_in;
   logic [63:0]   per_ff [SLOTS];
   logic          act_ff [SLOTS];
   logic [SLOTS-1:0] q_ff, q_in;
   logic [LW-1:0] lnk_ff [SLOTS];
   logic [LW-1:0] head_ff, head_in;
   logic [15:0]   imin_ff, imax_ff;
   logic [2:0]    cmd_ff;
   logic [63:0]   now_ff, when_ff, per_in_ff;
   logic          act_in_ff;
   logic [LW-1:0] tgt_ff, tgt_in;
   logic [LW-1:0] cur_ff, cur_in;
   logic          rdone_ff, rdone_in, idone_ff, idone_in;
   logic [64:0]   diff_ff;
   logic [15:0]   delay_ff, delay_in;
   logic          wr_lnk;
   logic [SW-1:0] wr_lnk_a;
   logic [LW-1:0] wr_lnk_d;
   logic          wr_cur;

   logic [SW-1:0] t_a, c_a, h_a, cn_a;
   logic [LW-1:0] cur_next;
   logic          tgt_ok;
   logic [63:0]   head_dl;

   assign t_a     = tgt_ff[SW-1:0];
   assign c_a     = cur_ff[SW-1:0];
   assign h_a     = head_ff[SW-1:0];
   assign tgt_ok  = tgt_ff < NO_LINK;
   assign cur_next = lnk_ff[c_a];
   assign cn_a    = cur_next[SW-1:0];
   assign head_dl = dl_ff[h_a];

   always_comb begin
      head_in  = head_ff;
      q_in     = q_ff;
      tgt_in   = tgt_ff;
      cur_in   = cur_ff;
      rdone_in = rdone_ff;
      idone_in = idone_ff;
      dl_in    = dl_ff[t_a];
      wr_lnk   = 1'b0;
      wr_lnk_a = t_a;
      wr_lnk_d = NO_LINK;
      wr_cur   = 1'b0;
      case (ctrl.op)
         dscq_pkg::OP_LOAD: begin
            tgt_in = (int'(req_slot) < SLOTS) ? LW'(req_slot) : NO_LINK;
         end
         dscq_pkg::OP_RM_START: begin
            q_in[t_a] = 1'b0;
            if (head_ff == tgt_ff) begin
               head_in  = lnk_ff[t_a];
               rdone_in = 1'b1;
            end else begin
               cur_in   = head_ff;
               rdone_in = 1'b0;
            end
         end
         dscq_pkg::OP_RM_STEP: begin
            if (cur_ff >= NO_LINK) begin
               rdone_in = 1'b1;
            end else if (cur_next == tgt_ff) begin
               wr_lnk   = 1'b1;
               wr_lnk_a = c_a;
               wr_lnk_d = lnk_ff[t_a];
               rdone_in = 1'b1;
            end else begin
               cur_in = cur_next;
            end
         end
         dscq_pkg::OP_WRITE: begin
            dl_in = (cmd_ff == dscq_pkg::CMD_ARM_AT) ? when_ff : now_ff + when_ff;
         end
         dscq_pkg::OP_CLEAR: begin
            dl_in = '0;
         end
         dscq_pkg::OP_REARM: begin
            dl_in = dl_ff[t_a] + per_ff[t_a];
         end
         dscq_pkg::OP_INS_START: begin
            q_in[t_a] = 1'b1;
            if (head_ff >= NO_LINK || dl_ff[t_a] < head_dl) begin
               wr_lnk   = 1'b1;
               wr_lnk_d = head_ff;
               head_in  = tgt_ff;
               idone_in = 1'b1;
            end else begin
               cur_in   = head_ff;
               idone_in = 1'b0;
            end
         end
         dscq_pkg::OP_INS_STEP: begin
            if (cur_next >= NO_LINK || dl_ff[t_a] < dl_ff[cn_a]) begin
               wr_lnk   = 1'b1;
               wr_lnk_d = cur_next;
               wr_cur   = 1'b1;
               idone_in = 1'b1;
            end else begin
               cur_in = cur_next;
            end
         end
         dscq_pkg::OP_FIRE: begin
            tgt_in = head_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.op == dscq_pkg::OP_LOAD) begin
         cmd_ff    <= req_cmd;
         now_ff    <= req_now;
         when_ff   <= req_when;
         per_in_ff <= req_period;
         act_in_ff <= req_action;
      end
      if (tgt_ok && (ctrl.op == dscq_pkg::OP_WRITE || ctrl.op == dscq_pkg::OP_CLEAR
            || ctrl.op == dscq_pkg::OP_REARM))
         dl_ff[t_a] <= dl_in;
      if (tgt_ok && ctrl.op == dscq_pkg::OP_WRITE) begin
         per_ff[t_a] <= per_in_ff;
         act_ff[t_a] <= act_in_ff;
      end
      if (tgt_ok && ctrl.op == dscq_pkg::OP_CLEAR)
         per_ff[t_a] <= '0;
      if (wr_lnk)
         lnk_ff[wr_lnk_a] <= wr_lnk_d;
      if (wr_cur)
         lnk_ff[c_a] <= tgt_ff;
      // head vs now, then clamp
      if (ctrl.op == dscq_pkg::OP_DELAY)
         diff_ff <= {1'b0, head_dl} - {1'b0, now_ff};
      tgt_ff   <= tgt_in;
      cur_ff   <= cur_in;
      rdone_ff <= rdone_in;
      idone_ff <= idone_in;
   end

   always_comb begin
      if (ctrl.op == dscq_pkg::OP_DELAY2) begin
         if (head_ff >= NO_LINK)
            delay_in = imax_ff;
         else if (diff_ff[64] || diff_ff[63:0] <= 64'(imin_ff))
            delay_in = imin_ff;
         else if (diff_ff[63:0] < 64'(imax_ff))
            delay_in = diff_ff[15:0];
         else
            delay_in = imax_ff;
      end else begin
         delay_in = delay_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff     <= '0;
         head_ff  <= NO_LINK;
         imin_ff  <= dscq_pkg::INTERVAL_MIN_RESET;
         imax_ff  <= dscq_pkg::INTERVAL_MAX_RESET;
         delay_ff <= '0;
      end else begin
         q_ff     <= q_in;
         head_ff  <= head_in;
         delay_ff <= delay_in;
         if (csr_we && csr_idx == dscq_pkg::CSR_INTERVAL_MIN) imin_ff <= csr_data;
         if (csr_we && csr_idx == dscq_pkg::CSR_INTERVAL_MAX) imax_ff <= csr_data;
      end
   end

   assign stat.target_queued = tgt_ok && q_ff[t_a];
   assign stat.target_ok     = tgt_ok;
   assign stat.rm_done       = rdone_ff;
   assign stat.ins_done      = idone_ff;
   assign stat.head_due      = (head_ff < NO_LINK) && (head_dl <= now_ff);
   assign stat.has_period    = per_ff[t_a] != 64'd0;
   assign fire_slot          = 4'(tgt_ff);
   assign fire_action        = act_ff[t_a];
   assign delay              = delay_ff;
   assign target_queued      = tgt_ok && q_ff[t_a];

endmodule

/* hw/rtl/dscq_controller.sv */
// ----------------------------------------------------------------------------
// dscq_controller
// Sequencer for arm, cancel, service and query requests.
// ----------------------------------------------------------------------------
module dscq_controller #(
   parameter int MAX_FIRES = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [2:0]          req_cmd,
   output dscq_pkg::ctrl_type  ctrl,
   input  dscq_pkg::stat_type  stat,
   input  logic [3:0]          fire_slot,
   input  logic                fire_action,
   input  logic [15:0]         delay,
   input  logic                target_queued,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata,
   output logic                rsp_tlast
);

   localparam int FW = $clog2(MAX_FIRES + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LOAD  = 4'd1;
   localparam logic [3:0] S_RM0   = 4'd2;
   localparam logic [3:0] S_RM    = 4'd3;
   localparam logic [3:0] S_WR    = 4'd4;
   localparam logic [3:0] S_INS0  = 4'd5;
   localparam logic [3:0] S_INS   = 4'd6;
   localparam logic [3:0] S_SVC   = 4'd7;
   localparam logic [3:0] S_FIRE  = 4'd8;
   localparam logic [3:0] S_REARM = 4'd9;
   localparam logic [3:0] S_DLY   = 4'd10;
   localparam logic [3:0] S_DLY2  = 4'd11;
   localparam logic [3:0] S_OUT   = 4'd12;

   logic [3:0]    st_ff, st_in;
   logic [2:0]    cmd_ff, cmd_in;
   logic [FW-1:0] cnt_ff, cnt_in;
   logic          more_ff, more_in, done_ff, done_in;
   logic [3:0]    fs_ff [MAX_FIRES];
   logic          fa_ff [MAX_FIRES];
   logic [FW-1:0] rd_ff, rd_in;
   logic [3:0]    rs_ff;
   logic          ra_ff;
   logic          pend_ff, pend_in;
   logic          fire_wr;
   logic          rsp_take;

   assign rsp_take = rsp_tvalid && rsp_tready;

   always_comb begin
      st_in    = st_ff;
      cmd_in   = cmd_ff;
      cnt_in   = cnt_ff;
      more_in  = more_ff;
      done_in  = done_ff;
      rd_in    = rd_ff;
      pend_in  = pend_ff;
      fire_wr  = 1'b0;
      ctrl.op  = dscq_pkg::OP_NONE;
      case (st_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ctrl.op = dscq_pkg::OP_LOAD;
               cmd_in  = req_cmd;
               cnt_in  = '0;
               more_in = 1'b0;
               done_in = 1'b0;
               st_in   = S_LOAD;
            end
         end
         S_LOAD: begin
            case (cmd_ff)
               dscq_pkg::CMD_ARM_AT, dscq_pkg::CMD_ARM_AFTER,
               dscq_pkg::CMD_CANCEL: begin
                  if (!stat.target_ok) st_in = S_DLY;
                  else if (stat.target_queued) st_in = S_RM0;
                  else st_in = S_WR;
               end
               dscq_pkg::CMD_SERVICE: st_in = S_SVC;
               dscq_pkg::CMD_QUERY: begin
                  done_in = !target_queued;
                  st_in   = S_DLY;
               end
               default: st_in = S_DLY;
            endcase
         end
         S_RM0: begin
            ctrl.op = dscq_pkg::OP_RM_START;
            st_in   = S_RM;
         end
         S_RM: begin
            if (stat.rm_done) begin
               st_in = (cmd_ff == dscq_pkg::CMD_SERVICE) ? S_FIRE : S_WR;
            end else begin
               ctrl.op = dscq_pkg::OP_RM_STEP;
            end
         end
         S_WR: begin
            if (cmd_ff == dscq_pkg::CMD_CANCEL) begin
               ctrl.op = dscq_pkg::OP_CLEAR;
               st_in   = S_DLY;
            end else begin
               ctrl.op = dscq_pkg::OP_WRITE;
               st_in   = S_INS0;
            end
         end
         S_INS0: begin
            ctrl.op = dscq_pkg::OP_INS_START;
            st_in   = S_INS;
         end
         S_INS: begin
            if (stat.ins_done) begin
               st_in = (cmd_ff == dscq_pkg::CMD_SERVICE) ? S_SVC : S_DLY;
            end else begin
               ctrl.op = dscq_pkg::OP_INS_STEP;
            end
         end
         S_SVC: begin
            if (stat.head_due && cnt_ff < FW'(MAX_FIRES)) begin
               ctrl.op = dscq_pkg::OP_FIRE;
               st_in   = S_RM0;
            end else begin
               more_in = stat.head_due;
               st_in   = S_DLY;
            end
         end
         S_FIRE: begin
            fire_wr = 1'b1;
            cnt_in  = cnt_ff + FW'(1);
            st_in   = stat.has_period ? S_REARM : S_SVC;
         end
         S_REARM: begin
            ctrl.op = dscq_pkg::OP_REARM;
            st_in   = S_INS0;
         end
         S_DLY: begin
            ctrl.op = dscq_pkg::OP_DELAY;
            st_in   = S_DLY2;
         end
         S_DLY2: begin
            ctrl.op = dscq_pkg::OP_DELAY2;
            rd_in   = '0;
            pend_in = 1'b1;
            st_in   = S_OUT;
         end
         S_OUT: begin
            // fetch stage feeding the result register
            if (rsp_take || !pend_ff) begin
               if (pend_ff && (cnt_ff == '0 || rd_ff + FW'(1) >= cnt_ff))
                  st_in = S_IDLE;
               else if (pend_ff)
                  rd_in = rd_ff + FW'(1);
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (fire_wr) begin
         fs_ff[cnt_ff[FW-1:0] < FW'(MAX_FIRES) ? cnt_ff[$clog2(MAX_FIRES > 1 ?
            MAX_FIRES : 2)-1:0] : '0] <= fire_slot;
         fa_ff[cnt_ff[$clog2(MAX_FIRES > 1 ? MAX_FIRES : 2)-1:0]] <= fire_action;
      end
      rs_ff <= fs_ff[rd_in[$clog2(MAX_FIRES > 1 ? MAX_FIRES : 2)-1:0]];
      ra_ff <= fa_ff[rd_in[$clog2(MAX_FIRES > 1 ? MAX_FIRES : 2)-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         cmd_ff  <= '0;
         cnt_ff  <= '0;
         more_ff <= 1'b0;
         done_ff <= 1'b0;
         rd_ff   <= '0;
         pend_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         cmd_ff  <= cmd_in;
         cnt_ff  <= cnt_in;
         more_ff <= more_in;
         done_ff <= done_in;
         rd_ff   <= rd_in;
         pend_ff <= (st_ff == S_OUT && st_in == S_IDLE) ? 1'b0 : pend_in;
      end
   end

   assign req_tready = (st_ff == S_IDLE);
   assign rsp_tvalid = (st_ff == S_OUT) && pend_ff;
   assign rsp_tlast  = (cnt_ff == '0) || (rd_ff + FW'(1) >= cnt_ff);
   assign rsp_tdata  = {more_ff, delay,
                        cnt_ff != '0 ? 1'b0 : done_ff,
                        cnt_ff != '0 ? ra_ff : 1'b0,
                        cnt_ff != '0 ? rs_ff : 4'd0,
                        cnt_ff != '0};

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> st_ff == S_OUT)
      else $error("result outside output state");
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FW'(MAX_FIRES))
      else $error("fire count over limit");
   assert property (@(posedge clock) disable iff (reset)
      (req_tready && req_tvalid) |=> st_ff == S_LOAD)
      else $error("accept without load");

endmodule

/* tb/deadline_sorted_callout_queue_core_test.sv */
// ----------------------------------------------------------------------------
// deadline_sorted_callout_queue_core_test
// Drives arm, cancel, service and query requests into the callout queue with
// random idling on both stream sides, predicts every response with a sorted
// slot list of its own and checks each response field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deadline_sorted_callout_queue_core_test;

   localparam int NSLOT = 16;
   localparam int FIRE_LIMIT = 64;
   localparam int NONE = NSLOT;
   localparam longint unsigned CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic        more_pending;
      logic [15:0] next_delay;
      logic        slot_done;
      logic        fired_action;
      logic [3:0]  fired_slot;
      logic        fired_valid;
   } rsp_fields_type;

   typedef struct {
      rsp_fields_type f;
      logic           last;
   } timer_rsp_type;

   class callout_scoreboard;
      logic [63:0]   deadline [NSLOT];
      logic [63:0]   period [NSLOT];
      logic          action [NSLOT];
      logic          queued [NSLOT];
      int            link [NSLOT];
      int            head;
      logic [15:0]   ival_min, ival_max;
      timer_rsp_type pending_rsp [$];
      int            errors;

      function void clear();
         for (int i = 0; i < NSLOT; i++) begin
            deadline[i] = '0; period[i] = '0; action[i] = 1'b0; queued[i] = 1'b0;
            link[i] = NONE;
         end
         head = NONE;
         ival_min = dscq_pkg::INTERVAL_MIN_RESET;
         ival_max = dscq_pkg::INTERVAL_MAX_RESET;
         errors = 0;
      endfunction

      function void unlink(int s);
         int p;
         if (head == s) head = link[s];
         else begin
            p = head;
            for (int n = 0; n < NSLOT && p < NSLOT; n++) begin
               if (link[p] == s) begin
                  link[p] = link[s];
                  break;
               end
               p = link[p];
            end
         end
         link[s] = NONE;
         queued[s] = 1'b0;
      endfunction

      function void enlist(int s);
         int c, nx;
         if (head >= NSLOT || deadline[s] < deadline[head]) begin
            link[s] = head;
            head = s;
         end else begin
            c = head;
            for (int n = 0; n < NSLOT; n++) begin
               nx = link[c];
               if (nx >= NSLOT || deadline[s] < deadline[nx]) begin
                  link[s] = nx;
                  link[c] = s;
                  break;
               end
               c = nx;
            end
         end
         queued[s] = 1'b1;
      endfunction

      function void note_request(logic [199:0] d);
         logic [2:0]    cmd;
         int            s, h, fires;
         logic [63:0]   now, whn, per, gap;
         logic          more, done;
         logic [15:0]   dly;
         int            fs [$];
         logic          fa [$];
         timer_rsp_type r;
         cmd = d[2:0]; s = int'(d[6:3]); now = d[70:7]; whn = d[134:71];
         per = d[198:135];
         more = 1'b0; done = 1'b0; fires = 0;
         if (cmd == dscq_pkg::CMD_ARM_AT || cmd == dscq_pkg::CMD_ARM_AFTER) begin
            if (queued[s]) unlink(s);
            deadline[s] = (cmd == dscq_pkg::CMD_ARM_AT) ? whn : now + whn;
            period[s] = per;
            action[s] = d[199];
            enlist(s);
         end else if (cmd == dscq_pkg::CMD_CANCEL) begin
            if (queued[s]) unlink(s);
            deadline[s] = '0;
            period[s] = '0;
         end else if (cmd == dscq_pkg::CMD_SERVICE) begin
            while (fires < FIRE_LIMIT && head < NSLOT && deadline[head] <= now) begin
               h = head;
               unlink(h);
               fs.push_back(h);
               fa.push_back(action[h]);
               fires++;
               if (period[h] != 0) begin
                  deadline[h] = deadline[h] + period[h];
                  enlist(h);
               end
            end
            more = head < NSLOT && deadline[head] <= now;
         end else if (cmd == dscq_pkg::CMD_QUERY) begin
            done = !queued[s];
         end
         if (head >= NSLOT) dly = ival_max;
         else begin
            gap = deadline[head] - now;
            if (deadline[head] <= now || gap <= 64'(ival_min)) dly = ival_min;
            else if (gap < 64'(ival_max)) dly = gap[15:0];
            else dly = ival_max;
         end
         if (fires == 0) begin
            r.f = '{more, dly, done, 1'b0, 4'd0, 1'b0};
            r.last = 1'b1;
            pending_rsp.push_back(r);
         end
         for (int k = 0; k < fires; k++) begin
            r.f = '{more, dly, 1'b0, fa[k], 4'(fs[k]), 1'b1};
            r.last = (k == fires - 1);
            pending_rsp.push_back(r);
         end
      endfunction

      function void check_response(logic [23:0] d, logic lst);
         rsp_fields_type a;
         timer_rsp_type  e;
         a = d;
         if (pending_rsp.size() == 0) begin
            $error("unexpected response %h", d);
            errors++;
            return;
         end
         e = pending_rsp.pop_front();
         if (a.fired_valid !== e.f.fired_valid) begin
            $error("fired_valid exp %0d got %0d", e.f.fired_valid, a.fired_valid);
            errors++;
         end
         if (a.fired_slot !== e.f.fired_slot) begin
            $error("fired_slot exp %0d got %0d", e.f.fired_slot, a.fired_slot);
            errors++;
         end
         if (a.fired_action !== e.f.fired_action) begin
            $error("fired_action exp %0d got %0d", e.f.fired_action, a.fired_action);
            errors++;
         end
         if (a.slot_done !== e.f.slot_done) begin
            $error("slot_done exp %0d got %0d", e.f.slot_done, a.slot_done);
            errors++;
         end
         if (a.next_delay !== e.f.next_delay) begin
            $error("next_delay exp %0d got %0d", e.f.next_delay, a.next_delay);
            errors++;
         end
         if (a.more_pending !== e.f.more_pending) begin
            $error("more_pending exp %0d got %0d", e.f.more_pending, a.more_pending);
            errors++;
         end
         if (lst !== e.last) begin
            $error("last exp %0d got %0d", e.last, lst);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [199:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [23:0]  rsp_tdata;
   logic         rsp_tlast;
   logic         csr_we = 0;
   logic         csr_idx = 0;
   logic [15:0]  csr_data = '0;

   callout_scoreboard timers;
   longint unsigned   cycles = 0;
   logic [63:0]       clk_now = 64'd1000;

   deadline_sorted_callout_queue_core u_top (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("deadline_sorted_callout_queue_core_test NOT OK");
         $finish;
      end
   end

   // response side: random stall, check on accept
   initial begin
      int w;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         w = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 12));
         if (w > 0) begin
            rsp_tready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         timers.check_response(rsp_tdata, rsp_tlast);
      end
   end

   task automatic send_request(logic [2:0] cmd, logic [3:0] s, logic [63:0] now,
                               logic [63:0] whn, logic [63:0] per, logic act);
      int w;
      w = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 12));
      if (w > 0) begin
         req_tvalid <= 1'b0;
         repeat (w) @(posedge clock);
      end
      req_tdata <= {act, per, whn, now, s, cmd};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      timers.note_request({act, per, whn, now, s, cmd});
   endtask

   task automatic write_csr(logic idx, logic [15:0] val);
      req_tvalid <= 1'b0;
      while (timers.pending_rsp.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      csr_we <= 1'b1; csr_idx <= idx; csr_data <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == dscq_pkg::CSR_INTERVAL_MIN) timers.ival_min = val;
      else timers.ival_max = val;
   endtask

   task automatic random_request();
      int          r;
      logic [63:0] whn, per;
      logic [3:0]  s;
      logic        a;
      r = int'($urandom_range(0, 99));
      clk_now = clk_now + 64'($urandom_range(0, 3000));
      if ($urandom_range(0, 4) == 0) whn = {$urandom, $urandom};
      else whn = 64'($urandom_range(0, 60000));
      if ($urandom_range(0, 2) == 0) per = '0;
      else if ($urandom_range(0, 9) == 0) per = {$urandom, $urandom};
      else per = 64'($urandom_range(1, 5000));
      s = 4'($urandom);
      a = 1'($urandom);
      if (r < 25)
         send_request(dscq_pkg::CMD_ARM_AFTER, s, clk_now, whn, per, a);
      else if (r < 40)
         send_request(dscq_pkg::CMD_ARM_AT, s, clk_now,
                      $urandom_range(0, 1) ? clk_now + whn : whn, per, a);
      else if (r < 50)
         send_request(dscq_pkg::CMD_CANCEL, s, clk_now, {$urandom, $urandom},
                      {$urandom, $urandom}, a);
      else if (r < 80)
         send_request(dscq_pkg::CMD_SERVICE, s, clk_now, {$urandom, $urandom},
                      {$urandom, $urandom}, a);
      else if (r < 95)
         send_request(dscq_pkg::CMD_QUERY, s, clk_now, {$urandom, $urandom},
                      {$urandom, $urandom}, a);
      else
         send_request(3'($urandom_range(5, 7)), s, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom}, a);
   endtask

   initial begin
      timers = new();
      timers.clear();
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed
      send_request(dscq_pkg::CMD_QUERY, 4'd0, 64'd0, 64'd0, 64'd0, 1'b0);
      send_request(dscq_pkg::CMD_SERVICE, 4'd0, 64'd0, 64'd0, 64'd0, 1'b0);
      send_request(dscq_pkg::CMD_ARM_AT, 4'd3, 64'd0, 64'd100, 64'd0, 1'b1);
      send_request(dscq_pkg::CMD_ARM_AT, 4'd5, 64'd0, 64'd100, 64'd0, 1'b0);
      send_request(dscq_pkg::CMD_ARM_AT, 4'd1, 64'd0, 64'd40, 64'd30, 1'b1);
      send_request(dscq_pkg::CMD_QUERY, 4'd3, 64'd0, 64'd0, 64'd0, 1'b0);
      send_request(dscq_pkg::CMD_ARM_AT, 4'd3, 64'd0, 64'd20, 64'd0, 1'b1);
      send_request(dscq_pkg::CMD_ARM_AFTER, 4'd15, '1, 64'd5, 64'd0, 1'b1);
      send_request(dscq_pkg::CMD_CANCEL, 4'd15, 64'd0, 64'd0, 64'd0, 1'b0);
      send_request(dscq_pkg::CMD_CANCEL, 4'd9, 64'd0, 64'd0, 64'd0, 1'b0);
      send_request(dscq_pkg::CMD_ARM_AT, 4'd7, 64'd0, '1, '1, 1'b1);
      send_request(dscq_pkg::CMD_ARM_AT, 4'd8, 64'd0, 64'd0, 64'd1, 1'b0);
      send_request(dscq_pkg::CMD_SERVICE, 4'd0, 64'd200, 64'd0, 64'd0, 1'b0);
      send_request(dscq_pkg::CMD_QUERY, 4'd5, 64'd0, 64'd0, 64'd0, 1'b0);
      send_request(3'd7, 4'd2, '1, '1, '1, 1'b1);
      for (int i = 0; i < NSLOT; i++)
         send_request(dscq_pkg::CMD_ARM_AT, 4'(i), 64'd0, 64'd1, 64'd1, 1'b1);
      send_request(dscq_pkg::CMD_SERVICE, 4'd0, 64'd10, 64'd0, 64'd0, 1'b0);
      send_request(dscq_pkg::CMD_SERVICE, 4'd0, 64'd10, 64'd0, 64'd0, 1'b0);
      for (int i = 0; i < NSLOT; i++)
         send_request(dscq_pkg::CMD_CANCEL, 4'(i), 64'd0, 64'd0, 64'd0, 1'b0);
      // random phases with several interval settings
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               write_csr(dscq_pkg::CSR_INTERVAL_MIN, 16'd1);
               write_csr(dscq_pkg::CSR_INTERVAL_MAX, 16'd65535);
            end
            1: begin
               write_csr(dscq_pkg::CSR_INTERVAL_MIN, 16'd65535);
               write_csr(dscq_pkg::CSR_INTERVAL_MAX, 16'd1);
            end
            2: begin
               write_csr(dscq_pkg::CSR_INTERVAL_MIN, 16'($urandom_range(1, 500)));
               write_csr(dscq_pkg::CSR_INTERVAL_MAX, 16'($urandom_range(500, 65535)));
            end
            3: begin
               write_csr(dscq_pkg::CSR_INTERVAL_MIN, 16'd1);
               write_csr(dscq_pkg::CSR_INTERVAL_MAX, 16'd1);
            end
            default: begin
               write_csr(dscq_pkg::CSR_INTERVAL_MIN, dscq_pkg::INTERVAL_MIN_RESET);
               write_csr(dscq_pkg::CSR_INTERVAL_MAX, dscq_pkg::INTERVAL_MAX_RESET);
            end
         endcase
         for (int i = 0; i < 11; i++) random_request();
      end
      req_tvalid <= 1'b0;
      while (timers.pending_rsp.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (timers.errors == 0 && timers.pending_rsp.size() == 0)
         $display("deadline_sorted_callout_queue_core_test OK");
      else
         $display("deadline_sorted_callout_queue_core_test NOT OK");
      $finish;
   end
endmodule
